// ===== src/kapq_pkg.sv =====
// Package for the key-frame aware packet queue: sizes, codes and word types.
`timescale 1ns / 1ps

package kapq_pkg;

  localparam int QUEUE_DEPTH = 128;
  localparam int HANDLE_BITS = 32;
  localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int MAXE_W      = 7;
  localparam int COUNT_BITS  = 8;
  localparam int CMP_W       = (CNT_W > MAXE_W) ? CNT_W : MAXE_W;
  localparam int ENTRY_W     = HANDLE_BITS + 1;

  localparam logic [CMP_W-1:0]   LIMIT_MAX     = CMP_W'(QUEUE_DEPTH - 1);
  localparam logic [MAXE_W-1:0]  MAX_ENTRIES_RST = MAXE_W'(100);
  localparam logic [ADDR_W-1:0]  LAST_ADDR     = ADDR_W'(QUEUE_DEPTH - 1);

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH_RD,
    ST_SCAN,
    ST_POP,
    ST_EMIT
  } state_e;

  typedef struct packed {
    op_e                    op;
    logic [HANDLE_BITS-1:0] packet_handle;
    logic                   key_frame;
  } in_t;

  typedef struct packed {
    logic                   pop_valid;
    logic [HANDLE_BITS-1:0] pop_handle;
    logic                   pop_key;
    logic [COUNT_BITS-1:0]  entry_count;
    logic [COUNT_BITS-1:0]  dropped_count;
  } out_t;

  function automatic logic [ADDR_W-1:0] next_addr(input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] r;
    r = (a == LAST_ADDR) ? '0 : a + 1'b1;
    return r;
  endfunction

endpackage

// ===== src/keyframe_aware_packet_queue.sv =====
// Top level of the key-frame aware packet queue with its entry memory and sequencer.
`timescale 1ns / 1ps

// Channel | Dir | Handshake                    | Word
// --------+-----+------------------------------+------------------------------
// in      | in  | in_valid_i / in_stall_o      | in_i  (op, handle, key flag)
// out     | out | out_valid_o / out_stall_i    | out_o (pop data, counts)
// cfg     | in  | cfg_we_i                     | cfg_data_i (max_entries)
//
// One word at a time. Push without overflow, clear, no-op and a pop on an empty
// queue go from idle straight to emit, a pop that returns an entry via the pop state.
// A push that overflows passes through the push-read and scan states; the scan
// drops head entries, stops at a key frame or an empty queue, and reads one head
// entry per cycle through the single read port of the entry memory.
// Reset clears pointers, count and limit (to 100); the memory is not cleared.
// A finished result waits in the output register, so the next word is taken
// while the previous one is stalled; a second result then waits in the sequencer.

module keyframe_aware_packet_queue (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  kapq_pkg::in_t                       in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output kapq_pkg::out_t                      out_o,
  input  logic                                cfg_we_i,
  input  logic [kapq_pkg::MAXE_W-1:0]         cfg_data_i
);

  kapq_pkg::state_e state_q, state_d;

  logic [kapq_pkg::ADDR_W-1:0]      head_q, head_d, tail_q, tail_d, rd_addr;
  logic [kapq_pkg::CNT_W-1:0]       count_q, count_d, drop_q, drop_d, count_inc;
  logic [kapq_pkg::MAXE_W-1:0]      max_q;
  logic [kapq_pkg::CMP_W-1:0]       limit;
  logic [kapq_pkg::ENTRY_W-1:0]     mem [kapq_pkg::QUEUE_DEPTH];
  logic [kapq_pkg::ENTRY_W-1:0]     rd_q;
  logic                             mem_we;
  logic                             res_pv_q, res_pv_d, res_pk_q, res_pk_d;
  logic [kapq_pkg::HANDLE_BITS-1:0] res_ph_q, res_ph_d;
  logic                             load_out;
  logic                             out_valid_q;
  kapq_pkg::out_t                   out_q;

  assign limit = (kapq_pkg::CMP_W'(max_q) > kapq_pkg::LIMIT_MAX) ?
                 kapq_pkg::LIMIT_MAX : kapq_pkg::CMP_W'(max_q);
  assign count_inc  = count_q + 1'b1;
  assign in_stall_o = (state_q != kapq_pkg::ST_IDLE);

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    drop_d   = drop_q;
    res_pv_d = res_pv_q;
    res_ph_d = res_ph_q;
    res_pk_d = res_pk_q;
    rd_addr  = head_q;
    mem_we   = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      kapq_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          drop_d   = '0;
          res_pv_d = 1'b0;
          res_ph_d = '0;
          res_pk_d = 1'b0;
          unique case (in_i.op)
            kapq_pkg::OP_PUSH: begin
              mem_we  = 1'b1;
              tail_d  = kapq_pkg::next_addr(tail_q);
              count_d = count_inc;
              state_d = (kapq_pkg::CMP_W'(count_inc) > limit) ?
                        kapq_pkg::ST_PUSH_RD : kapq_pkg::ST_EMIT;
            end
            kapq_pkg::OP_POP: begin
              // The head is read on this edge; its data is used in the pop state.
              state_d = (count_q != '0) ? kapq_pkg::ST_POP : kapq_pkg::ST_EMIT;
            end
            kapq_pkg::OP_CLEAR: begin
              head_d  = '0;
              tail_d  = '0;
              count_d = '0;
              state_d = kapq_pkg::ST_EMIT;
            end
            kapq_pkg::OP_NOP: begin
              state_d = kapq_pkg::ST_EMIT;
            end
          endcase
        end
      end
      kapq_pkg::ST_PUSH_RD: begin
        // The pushed word is already in memory, so the head read sees it.
        state_d = kapq_pkg::ST_SCAN;
      end
      kapq_pkg::ST_SCAN: begin
        if (rd_q[0] && drop_q != '0) begin
          state_d = kapq_pkg::ST_EMIT;
        end else begin
          // A key frame at the head on the first look is dropped alone.
          head_d  = kapq_pkg::next_addr(head_q);
          count_d = count_q - 1'b1;
          drop_d  = drop_q + 1'b1;
          rd_addr = kapq_pkg::next_addr(head_q);
          if (rd_q[0] || count_q == kapq_pkg::CNT_W'(1)) begin
            state_d = kapq_pkg::ST_EMIT;
          end
        end
      end
      kapq_pkg::ST_POP: begin
        res_pv_d = 1'b1;
        res_ph_d = rd_q[kapq_pkg::ENTRY_W-1:1];
        res_pk_d = rd_q[0];
        head_d   = kapq_pkg::next_addr(head_q);
        count_d  = count_q - 1'b1;
        state_d  = kapq_pkg::ST_EMIT;
      end
      kapq_pkg::ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = kapq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = kapq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kapq_pkg::ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      drop_q      <= '0;
      max_q       <= kapq_pkg::MAX_ENTRIES_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      drop_q  <= drop_d;
      if (cfg_we_i) begin
        max_q <= cfg_data_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_pv_q <= res_pv_d;
    res_ph_q <= res_ph_d;
    res_pk_q <= res_pk_d;
    if (load_out) begin
      out_q.pop_valid     <= res_pv_q;
      out_q.pop_handle    <= res_ph_q;
      out_q.pop_key       <= res_pk_q;
      out_q.entry_count   <= kapq_pkg::COUNT_BITS'(count_q);
      out_q.dropped_count <= kapq_pkg::COUNT_BITS'(drop_q);
    end
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[tail_q] <= {in_i.packet_handle, in_i.key_frame};
    end
    rd_q <= mem[rd_addr];
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== src/kapq_checker.sv =====
// Port-level checker for the key-frame aware packet queue and its bind.
`timescale 1ns / 1ps

module kapq_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input kapq_pkg::out_t              out_o
);

  // A stalled result word stays and holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result word changed or vanished");

  // After a word is taken the queue is busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after an accept");

  // A new result only shows up while an input word is being worked on.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a word in work");

  // Pop data is zero unless a pop returned an entry, and a pop drops nothing.
  a_pop_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.pop_valid ? (out_o.dropped_count == '0) :
                     (out_o.pop_handle == '0 && out_o.pop_key == 1'b0)))
    else $error("pop fields inconsistent");

endmodule

bind keyframe_aware_packet_queue kapq_checker u_kapq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_o       (out_o)
);

// ===== sim/tb.sv =====
// Self-checking testbench for the key-frame aware packet queue.
`timescale 1ns / 1ps

module tb;

  localparam int QUIET_LIMIT = 5000;
  localparam int LONG_HOLD   = 300;

  // Shadow copy of the queue: predicts the result word for every accepted
  // input word and checks the words coming out in order.
  class queue_shadow;
    logic [kapq_pkg::HANDLE_BITS-1:0] slot_handle [kapq_pkg::QUEUE_DEPTH];
    logic                             slot_key    [kapq_pkg::QUEUE_DEPTH];
    int unsigned                      head;
    int unsigned                      tail;
    int unsigned                      held;
    int unsigned                      limit;
    kapq_pkg::out_t                   awaited_results [$];
    int unsigned                      errors;

    function new();
      head   = 0;
      tail   = 0;
      held   = 0;
      limit  = 32'(kapq_pkg::MAX_ENTRIES_RST);
      errors = 0;
    endfunction

    function void take_head();
      head = (head + 1) % kapq_pkg::QUEUE_DEPTH;
      held--;
    endfunction

    function void absorb_word(input kapq_pkg::in_t w);
      kapq_pkg::out_t r;
      int unsigned    cap;
      int unsigned    dropped;
      r       = '0;
      dropped = 0;
      case (w.op)
        kapq_pkg::OP_PUSH: begin
          cap = (limit > kapq_pkg::QUEUE_DEPTH - 1) ? kapq_pkg::QUEUE_DEPTH - 1 : limit;
          slot_handle[tail] = w.packet_handle;
          slot_key[tail]    = w.key_frame;
          tail = (tail + 1) % kapq_pkg::QUEUE_DEPTH;
          held++;
          if (held > cap) begin
            // A key frame at the head goes alone; otherwise the scan runs
            // up to the next key frame or until the queue is empty.
            if (slot_key[head]) begin
              take_head();
              dropped = 1;
            end else begin
              while (held > 0 && !slot_key[head]) begin
                take_head();
                dropped++;
              end
            end
          end
        end
        kapq_pkg::OP_POP: begin
          if (held > 0) begin
            r.pop_valid  = 1'b1;
            r.pop_handle = slot_handle[head];
            r.pop_key    = slot_key[head];
            take_head();
          end
        end
        kapq_pkg::OP_CLEAR: begin
          head = 0;
          tail = 0;
          held = 0;
        end
        default: ;
      endcase
      r.entry_count   = kapq_pkg::COUNT_BITS'(held);
      r.dropped_count = kapq_pkg::COUNT_BITS'(dropped);
      awaited_results.insert(awaited_results.size(), r);
    endfunction

    function void compare_field(input string name, input longint unsigned want,
                                input longint unsigned got);
      if (want != got) begin
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(input kapq_pkg::out_t got);
      kapq_pkg::out_t want;
      if (awaited_results.size() == 0) begin
        $display("%0t ns: result word with nothing awaited, expected none, actual 0x%0h",
                 $time, got);
        errors++;
        return;
      end
      want = awaited_results[0];
      awaited_results.delete(0);
      compare_field("pop_valid", want.pop_valid, got.pop_valid);
      compare_field("pop_handle", want.pop_handle, got.pop_handle);
      compare_field("pop_key", want.pop_key, got.pop_key);
      compare_field("entry_count", want.entry_count, got.entry_count);
      compare_field("dropped_count", want.dropped_count, got.dropped_count);
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction
  endclass

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_stall_o;
  kapq_pkg::in_t               in_i        = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  kapq_pkg::out_t              out_o;
  logic                        cfg_we_i    = 1'b0;
  logic [kapq_pkg::MAXE_W-1:0] cfg_data_i  = '0;

  queue_shadow shadow;
  bit          long_hold_req = 1'b0;
  int          quiet_cycles  = 0;

  always #5 clk_i = ~clk_i;

  keyframe_aware_packet_queue u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  task automatic send_word(input kapq_pkg::in_t w);
    in_valid_i <= 1'b1;
    in_i       <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    shadow.absorb_word(w);
  endtask

  task automatic send_op(input kapq_pkg::op_e op,
                         input logic [kapq_pkg::HANDLE_BITS-1:0] h, input logic k);
    kapq_pkg::in_t w;
    w.op            = op;
    w.packet_handle = h;
    w.key_frame     = k;
    send_word(w);
  endtask

  // Always advances at least one clock, so a following assignment lands in a new step.
  task automatic wait_drained();
    do @(posedge clk_i); while (shadow.pending() != 0);
  endtask

  task automatic write_limit(input logic [kapq_pkg::MAXE_W-1:0] v);
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    shadow.limit = 32'(v);
  endtask

  function automatic kapq_pkg::in_t make_word(input int push_pct, input int pop_pct,
                                              input int key_pct);
    kapq_pkg::in_t w;
    int            r;
    r = $urandom_range(0, 99);
    case ($urandom_range(0, 15))
      0:       w.packet_handle = '0;
      1:       w.packet_handle = '1;
      default: w.packet_handle = $urandom;
    endcase
    w.key_frame = ($urandom_range(0, 99) < key_pct);
    if (r < push_pct) begin
      w.op = kapq_pkg::OP_PUSH;
    end else if (r < push_pct + pop_pct) begin
      w.op = kapq_pkg::OP_POP;
    end else if (r[0]) begin
      w.op = kapq_pkg::OP_CLEAR;
    end else begin
      w.op = kapq_pkg::OP_NOP;
    end
    return w;
  endfunction

  // Receiver: checks accepted result words and stalls in modes of random length.
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) shadow.check_result(out_o);
      if (long_hold_req) begin
        hold_left     = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(5, 60);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 99) < 30);
          default: out_stall_i <= ($urandom_range(0, 99) < 75);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && !((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))) begin
      quiet_cycles = quiet_cycles + 1;
    end else begin
      quiet_cycles = 0;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t ns: no word moved for %0d cycles", $time, QUIET_LIMIT);
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    static int lim_tab  [6] = '{127, 1, 5, 42, 85, 3};
    static int len_tab  [6] = '{300, 150, 200, 130, 150, 120};
    static int push_tab [6] = '{95, 55, 60, 70, 88, 50};
    static int pop_tab  [6] = '{5, 35, 30, 22, 8, 38};
    static int key_tab  [6] = '{30, 25, 15, 40, 20, 10};
    int burst_left;
    int gap;
    shadow     = new();
    burst_left = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset limit: empty pop, unused op, extreme handles.
    send_op(kapq_pkg::OP_POP, $urandom, 1'b1);
    send_op(kapq_pkg::OP_NOP, '1, 1'b1);
    send_op(kapq_pkg::OP_PUSH, '0, 1'b0);
    send_op(kapq_pkg::OP_PUSH, '1, 1'b1);
    send_op(kapq_pkg::OP_PUSH, $urandom, 1'b0);
    send_op(kapq_pkg::OP_POP, '0, 1'b0);
    send_op(kapq_pkg::OP_POP, '0, 1'b0);
    send_op(kapq_pkg::OP_CLEAR, '1, 1'b1);
    send_op(kapq_pkg::OP_POP, '0, 1'b0);

    // Overflow with a key frame at the head, then scans that empty the queue
    // and that stop at a key frame.
    write_limit(kapq_pkg::MAXE_W'(2));
    send_op(kapq_pkg::OP_PUSH, $urandom, 1'b1);
    send_op(kapq_pkg::OP_PUSH, $urandom, 1'b0);
    send_op(kapq_pkg::OP_PUSH, $urandom, 1'b0);
    send_op(kapq_pkg::OP_PUSH, $urandom, 1'b0);
    send_op(kapq_pkg::OP_PUSH, $urandom, 1'b0);
    send_op(kapq_pkg::OP_PUSH, $urandom, 1'b0);
    send_op(kapq_pkg::OP_PUSH, $urandom, 1'b1);

    // A limit of zero makes every push drop.
    write_limit(kapq_pkg::MAXE_W'(0));
    send_op(kapq_pkg::OP_PUSH, $urandom, 1'b0);
    send_op(kapq_pkg::OP_PUSH, $urandom, 1'b1);
    send_op(kapq_pkg::OP_POP, '0, 1'b0);

    for (int p = 0; p < 6; p++) begin
      write_limit(kapq_pkg::MAXE_W'(lim_tab[p]));
      // The long receiver hold starts while the queue is filling to its maximum.
      if (p == 0) long_hold_req = 1'b1;
      for (int i = 0; i < len_tab[p]; i++) begin
        if (p == 2 && i == len_tab[p] / 2) begin
          in_valid_i <= 1'b0;
          wait_drained();
        end else if (burst_left <= 0) begin
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          if (gap > 0) begin
            in_valid_i <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
          burst_left = ($urandom_range(0, 4) == 0) ? 80 : $urandom_range(1, 16);
        end
        burst_left--;
        send_word(make_word(push_tab[p], pop_tab[p], key_tab[p]));
      end
    end

    in_valid_i <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (shadow.errors == 0 && shadow.pending() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
